>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/ucal_pkg.sv
package ucal_pkg;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // Each division by a constant first shifts off the power-of-two part of the divisor and
    // then multiplies by a rounded-up reciprocal of the odd part. The reciprocal error stays
    // below one step over the whole dividend range, so the quotients are exact.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675 for (secs >> 7)
    localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225 for (rem >> 4)
    localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15 for (rem >> 2)

    localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
    localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;
    localparam logic [8:0]  YEAR_DAYS        = 9'd365;
    localparam logic [8:0]  YEAR_DAYS_LEAP   = 9'd366;
    localparam logic [3:0]  LAST_MONTH_IDX   = 4'd11;

    typedef struct packed {
        logic load_secs;
        logic day_div;
        logic day_rem;
        logic hour_div;
        logic hour_rem;
        logic min_div;
        logic min_rem;
        logic year_step;
        logic month_step;
        logic out_load;
    } ucal_cmd_t;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } ucal_status_t;

    function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
        logic [4:0] n;
        case (idx) inside
            4'd1:                   n = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
            default:                n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

>>> src/ucal_datapath.sv
module ucal_datapath (
    input  logic                    clk,
    input  logic [31:0]             epoch_seconds,
    input  ucal_pkg::ucal_cmd_t     cmd,
    output ucal_pkg::ucal_status_t  status,
    output logic [11:0]             cal_year,
    output logic [3:0]              cal_month,
    output logic [4:0]              cal_day,
    output logic [4:0]              cal_hour,
    output logic [5:0]              cal_minute,
    output logic [5:0]              cal_second
);

    logic [31:0] secs_reg, secs_next;
    logic [16:0] rem_reg, rem_next;
    logic [11:0] hrem_reg, hrem_next;
    logic [15:0] days_reg, days_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  mon_reg, mon_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;

    logic [11:0] cal_year_reg;
    logic [3:0]  cal_month_reg;
    logic [4:0]  cal_day_reg;
    logic [4:0]  cal_hour_reg;
    logic [5:0]  cal_minute_reg;
    logic [5:0]  cal_second_reg;

    logic [50:0] day_prod;
    logic [16:0] day_back;
    logic [26:0] hour_prod;
    logic [11:0] hour_back;
    logic [20:0] min_prod;
    logic [5:0]  min_back;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    always_comb
    begin
        day_prod  = {26'b0, secs_reg[31:7]} * {25'b0, ucal_pkg::DAY_RECIP};
        hour_prod = {14'b0, rem_reg[16:4]} * {13'b0, ucal_pkg::HOUR_RECIP};
        min_prod  = {11'b0, hrem_reg[11:2]} * {10'b0, ucal_pkg::MIN_RECIP};

        // The remainders are known to fit, so the products are only needed modulo their width.
        day_back  = {1'b0, days_reg} * ucal_pkg::SECS_PER_DAY;
        hour_back = {7'b0, hour_reg} * ucal_pkg::SECS_PER_HOUR;
        min_back  = min_reg * ucal_pkg::SECS_PER_MIN;

        // Within 1970..2106 the only centuries are 2000, which is divisible by 400 and
        // therefore leap, and 2100, which is not a leap year.
        leap = (year_reg[1:0] == 2'b00) && (year_reg != ucal_pkg::NON_LEAP_CENTURY);
        ylen = leap ? ucal_pkg::YEAR_DAYS_LEAP : ucal_pkg::YEAR_DAYS;
        mlen = ucal_pkg::month_days(mon_reg, leap);

        status.year_fits  = days_reg < {7'b0, ylen};
        status.month_fits = (mon_reg == ucal_pkg::LAST_MONTH_IDX) ||
                            (days_reg < {11'b0, mlen});
    end

    always_comb
    begin
        secs_next = secs_reg;
        rem_next  = rem_reg;
        hrem_next = hrem_reg;
        days_next = days_reg;
        year_next = year_reg;
        mon_next  = mon_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;

        if (cmd.load_secs)
        begin
            secs_next = epoch_seconds;
            year_next = ucal_pkg::EPOCH_YEAR;
            mon_next  = '0;
        end
        if (cmd.day_rem)
        begin
            rem_next = secs_reg[16:0] - day_back;
        end
        if (cmd.hour_div)
        begin
            hour_next = hour_prod[25:21];
        end
        if (cmd.hour_rem)
        begin
            hrem_next = rem_reg[11:0] - hour_back;
        end
        if (cmd.min_div)
        begin
            min_next = min_prod[19:14];
        end
        if (cmd.min_rem)
        begin
            sec_next = hrem_reg[5:0] - min_back;
        end

        if (cmd.day_div)
        begin
            days_next = day_prod[50:35];
        end
        else if (cmd.year_step)
        begin
            days_next = days_reg - {7'b0, ylen};
            year_next = year_reg + 12'd1;
        end
        else if (cmd.month_step)
        begin
            days_next = days_reg - {11'b0, mlen};
            mon_next  = mon_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg <= secs_next;
        rem_reg  <= rem_next;
        hrem_reg <= hrem_next;
        days_reg <= days_next;
        year_reg <= year_next;
        mon_reg  <= mon_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        if (cmd.out_load)
        begin
            cal_year_reg   <= year_reg;
            cal_month_reg  <= mon_reg + 4'd1;
            cal_day_reg    <= days_reg[4:0] + 5'd1;
            cal_hour_reg   <= hour_reg;
            cal_minute_reg <= min_reg;
            cal_second_reg <= sec_reg;
        end
    end

    assign cal_year   = cal_year_reg;
    assign cal_month  = cal_month_reg;
    assign cal_day    = cal_day_reg;
    assign cal_hour   = cal_hour_reg;
    assign cal_minute = cal_minute_reg;
    assign cal_second = cal_second_reg;

endmodule

>>> src/ucal_ctrl.sv
module ucal_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    output ucal_pkg::ucal_cmd_t     cmd,
    input  ucal_pkg::ucal_status_t  status
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DAY_DIV  = 4'd1;
    localparam logic [3:0] ST_DAY_REM  = 4'd2;
    localparam logic [3:0] ST_HOUR_DIV = 4'd3;
    localparam logic [3:0] ST_HOUR_REM = 4'd4;
    localparam logic [3:0] ST_MIN_DIV  = 4'd5;
    localparam logic [3:0] ST_MIN_REM  = 4'd6;
    localparam logic [3:0] ST_YEAR     = 4'd7;
    localparam logic [3:0] ST_MONTH    = 4'd8;
    localparam logic [3:0] ST_DONE     = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_secs = 1'b1;
                    state_next    = ST_DAY_DIV;
                end
            end
            ST_DAY_DIV:
            begin
                cmd.day_div = 1'b1;
                state_next  = ST_DAY_REM;
            end
            ST_DAY_REM:
            begin
                cmd.day_rem = 1'b1;
                state_next  = ST_HOUR_DIV;
            end
            ST_HOUR_DIV:
            begin
                cmd.hour_div = 1'b1;
                state_next   = ST_HOUR_REM;
            end
            ST_HOUR_REM:
            begin
                cmd.hour_rem = 1'b1;
                state_next   = ST_MIN_DIV;
            end
            ST_MIN_DIV:
            begin
                cmd.min_div = 1'b1;
                state_next  = ST_MIN_REM;
            end
            ST_MIN_REM:
            begin
                cmd.min_rem = 1'b1;
                state_next  = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (status.year_fits)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                if (status.month_fits)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                // The output register takes the word once the previous one is gone.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> src/unix_seconds_to_calendar.sv
// A word is converted in steps: six multiply steps split the seconds, then a loop subtracts
// one year per step for the Y (0..136) whole years past 1970 and one month per step for the
// M (0..11) whole months past January; the result then waits in the done state until the
// previous result leaves the output register. The year subtraction loop is the longest part.
// Throughput: one word at a time; the next input is taken in the cycle after the result moves
// into the output register. Reset (rst_n, asynchronous, active low) idles and drops out_valid.
module unix_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] cal_year,
    output logic [3:0]  cal_month,
    output logic [4:0]  cal_day,
    output logic [4:0]  cal_hour,
    output logic [5:0]  cal_minute,
    output logic [5:0]  cal_second
);

    ucal_pkg::ucal_cmd_t    cmd;
    ucal_pkg::ucal_status_t status;

    ucal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    ucal_datapath u_datapath (
        .clk           (clk),
        .epoch_seconds (epoch_seconds),
        .cmd           (cmd),
        .status        (status),
        .cal_year      (cal_year),
        .cal_month     (cal_month),
        .cal_day       (cal_day),
        .cal_hour      (cal_hour),
        .cal_minute    (cal_minute),
        .cal_second    (cal_second)
    );

endmodule

>>> src/ucal_checker.sv
`include "assert_macros.svh"

module ucal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] epoch_seconds,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] cal_year,
    input logic [3:0]  cal_month,
    input logic [4:0]  cal_day,
    input logic [4:0]  cal_hour,
    input logic [5:0]  cal_minute,
    input logic [5:0]  cal_second
);

    // Once a word is taken the block is busy converting it.
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    `ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(epoch_seconds))

    `ASSERT_SAME(a_time_range, out_valid,
        (cal_hour <= 5'd23) && (cal_minute <= 6'd59) && (cal_second <= 6'd59))

    `ASSERT_SAME(a_date_range, out_valid,
        (cal_year >= 12'd1970) && (cal_year <= 12'd2106) && (cal_month >= 4'd1) &&
        (cal_month <= 4'd12) && (cal_day >= 5'd1))

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(cal_year) && $stable(cal_month) && $stable(cal_day) &&
        $stable(cal_hour) && $stable(cal_minute) && $stable(cal_second))

endmodule

bind unix_seconds_to_calendar ucal_checker u_checker (.*);

>>> tb/tb.sv
module tb;

    localparam int unsigned CYCLE_LIMIT = 4000000;
    // Leave room beyond the longest conversion at the end.
    localparam int unsigned DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_time_t;

    typedef struct packed {
        logic [31:0] secs;
        date_time_t  date;
    } pending_date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] epoch_seconds = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;

    pending_date_t expected_dates[$];
    int unsigned   words_sent = 0;
    int unsigned   dates_checked = 0;
    int unsigned   errors = 0;
    int unsigned   cycle_count = 0;

    unix_seconds_to_calendar uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .epoch_seconds (epoch_seconds),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cal_year      (cal_year),
        .cal_month     (cal_month),
        .cal_day       (cal_day),
        .cal_hour      (cal_hour),
        .cal_minute    (cal_minute),
        .cal_second    (cal_second)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit leap_of(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Month index is zero based, January is 0.
    function automatic int unsigned month_length(input int unsigned idx, input bit leap);
        int unsigned n;
        case (idx)
            1:             n = leap ? 29 : 28;
            3, 5, 8, 10:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    function automatic date_time_t calendar_of(input logic [31:0] s);
        int unsigned secs;
        int unsigned days;
        int unsigned rest;
        int unsigned y;
        int unsigned m;
        bit          month_done;
        date_time_t  r;
        secs = s;
        days = secs / 86400;
        rest = secs % 86400;
        r.hour = 5'(rest / 3600);
        rest = rest % 3600;
        r.minute = 6'(rest / 60);
        r.second = 6'(rest % 60);
        y = 1970;
        while (days >= (leap_of(y) ? 366 : 365))
        begin
            days = days - (leap_of(y) ? 366 : 365);
            y++;
        end
        m = 0;
        month_done = 1'b0;
        while (m < 11 && !month_done)
        begin
            if (days < month_length(m, leap_of(y)))
                month_done = 1'b1;
            else
            begin
                days = days - month_length(m, leap_of(y));
                m++;
            end
        end
        r.year = 12'(y);
        r.month = 4'(m + 1);
        r.day = 5'(days + 1);
        return r;
    endfunction

    function automatic longint seconds_at(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s);
        longint      days;
        int unsigned k;
        days = 0;
        for (k = 1970; k < y; k++)
            days = days + (leap_of(k) ? 366 : 365);
        for (k = 1; k < mo; k++)
            days = days + month_length(k - 1, leap_of(y));
        days = days + d - 1;
        return days * 86400 + h * 3600 + mi * 60 + s;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int unsigned idle_length(input int unsigned long_max);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 20);
        else
            return $urandom_range(21, long_max);
    endfunction

    task automatic send_seconds(input logic [31:0] s);
        int unsigned gap;
        pending_date_t entry;
        gap = idle_length(150);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            epoch_seconds <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        epoch_seconds <= s;
        do
            @(posedge clk);
        while (in_stall);
        entry.secs = s;
        entry.date = calendar_of(s);
        expected_dates.push_back(entry);
        words_sent++;
    endtask

    task automatic send_date(input int unsigned y, input int unsigned mo, input int unsigned d,
                             input int unsigned h, input int unsigned mi, input int unsigned s);
        send_seconds(32'(seconds_at(y, mo, d, h, mi, s)));
    endtask

    task automatic test_extremes();
        send_seconds(32'd0);
        send_seconds(32'd1);
        send_seconds(32'd59);
        send_seconds(32'd60);
        send_seconds(32'd3599);
        send_seconds(32'd3600);
        send_seconds(32'd86399);
        send_seconds(32'd86400);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'hFFFF_FFFE);
        send_seconds(32'h7FFF_FFFF);
        send_seconds(32'h8000_0000);
        send_seconds(32'h5555_5555);
        send_seconds(32'hAAAA_AAAA);
    endtask

    // Leap days, the last day of a leap year, the century leap year 2000 and
    // the non-leap century 2100.
    task automatic test_leap_rules();
        send_date(1970, 12, 31, 23, 59, 59);
        send_date(1971, 1, 1, 0, 0, 0);
        send_date(1972, 2, 29, 0, 0, 0);
        send_date(1972, 12, 31, 23, 59, 59);
        send_date(2000, 2, 29, 12, 0, 0);
        send_date(2000, 3, 1, 0, 0, 0);
        send_date(2100, 2, 28, 23, 59, 59);
        send_date(2100, 3, 1, 0, 0, 0);
        send_date(2104, 2, 29, 6, 30, 30);
    endtask

    // Words a few seconds or a few days around the first of a random month.
    task automatic test_calendar_edges(input int unsigned count);
        int unsigned n;
        int unsigned y;
        int unsigned mo;
        longint      t;
        for (n = 0; n < count; n++)
        begin
            y = $urandom_range(1970, 2106);
            mo = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
                mo = $urandom_range(2, 3);
            t = seconds_at(y, mo, 1, 0, 0, 0);
            if ($urandom_range(0, 1) == 0)
                t = t + $urandom_range(0, 8) - 4;
            else
                t = t + (longint'($urandom_range(0, 4)) - 2) * 86400 + $urandom_range(0, 86399);
            if (t < 0 || t > 64'hFFFF_FFFF)
                t = $urandom;
            send_seconds(t[31:0]);
        end
    endtask

    task automatic test_random_seconds(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++)
            send_seconds($urandom);
    endtask

    task automatic check_field(input logic [31:0] secs, input string name,
                               input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch for word %0d, expected %0d, actual %0d",
                     $time, name, secs, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        pending_date_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_dates.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                         $time, cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second);
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                check_field(want.secs, "year", want.date.year, cal_year);
                check_field(want.secs, "month", want.date.month, cal_month);
                check_field(want.secs, "day", want.date.day, cal_day);
                check_field(want.secs, "hour", want.date.hour, cal_hour);
                check_field(want.secs, "minute", want.date.minute, cal_minute);
                check_field(want.secs, "second", want.date.second, cal_second);
                dates_checked++;
            end
        end
    end

    // Output stall pattern: free stretches and stalls in random order, mostly short.
    initial
    begin
        int unsigned run;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                out_stall <= 1'b0;
                run = $urandom_range(1, 40);
            end
            else
            begin
                out_stall <= 1'b1;
                run = idle_length(200) + 1;
            end
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_dates.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_leap_rules();
        test_calendar_edges(400);
        test_random_seconds(830);
        in_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Converted %0d words and checked %0d dates, from the epoch to the top of",
                 words_sent, dates_checked);
        $display("the 32-bit range, with leap days, month ends and the 2100 century rule.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
